FILE: rtl/uds_fds_pkg.sv
// ----------------------------------------------------------------------------
// Flash download sequencer package
// Shared types, codes and byte constants for the sequencer modules.
// ----------------------------------------------------------------------------
package uds_fds_pkg;

  // Register indexes on the configuration port.
  localparam logic [7:0] REG_FILE_TYPE   = 8'd0;
  localparam logic [7:0] REG_UPDATE_TYPE = 8'd1;
  localparam logic [7:0] REG_MEM_ADDR    = 8'd2;
  localparam logic [7:0] REG_MEM_SIZE    = 8'd3;
  localparam logic [7:0] REG_IMAGE_LEN   = 8'd4;
  localparam logic [7:0] REG_BEGIN_PROG  = 8'd5;
  localparam logic [7:0] REG_END_PROG    = 8'd6;
  localparam logic [7:0] REG_HAS_FS      = 8'd7;

  // Input modes.
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_RESP  = 2'd1;
  localparam logic [1:0] MODE_DATA  = 2'd2;

  // Final status codes.
  localparam logic [1:0] ST_SUCCESS = 2'd0;
  localparam logic [1:0] ST_NEG     = 2'd1;
  localparam logic [1:0] ST_BAD_FT  = 2'd2;
  localparam logic [1:0] ST_BAD_LEN = 2'd3;

  // Service identifiers and fixed request bytes.
  localparam logic [7:0] SID_ROUTINE  = 8'h31;
  localparam logic [7:0] SID_DOWNLOAD = 8'h34;
  localparam logic [7:0] SID_TRANSFER = 8'h36;
  localparam logic [7:0] SID_EXIT     = 8'h37;
  localparam logic [7:0] BYTE_FMT     = 8'h44;
  localparam logic [7:0] BYTE_FF      = 8'hFF;
  localparam logic [7:0] BYTE_01      = 8'h01;
  localparam logic [7:0] BYTE_00      = 8'h00;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [6:0]  PROG_MAX    = 7'd100;

  typedef enum logic [2:0] {
    MSG_ERASE,
    MSG_DL,
    MSG_BLOCK,
    MSG_EXIT,
    MSG_CHECK,
    MSG_DATA
  } msg_e;

  typedef struct packed {
    logic [1:0]  file_type;
    logic [1:0]  update_type;
    logic [31:0] memory_addr;
    logic [31:0] memory_size;
    logic [31:0] image_length;
    logic [6:0]  begin_progress;
    logic [6:0]  end_progress;
    logic        has_file_system;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start;      // clear sequence state, load begin progress
    logic [1:0] prog_add;   // add to progress, saturating
    logic       prog_div;   // load progress from the block fraction
    logic       prog_end;   // load end progress (shown on this word)
    logic       load_block; // take block length from the reply tail
    logic       new_block;  // bump counter, size the next block
    logic       data_step;  // CRC, count and consume one data byte
    logic       div_start;  // start the progress fraction division
    logic       latch;      // capture the incoming data byte
    msg_e       msg;        // request being emitted
    logic [3:0] idx;        // byte index within the request
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic left_nz;
    logic left_one;
    logic sent_ge_len;
    logic div_busy;
    logic msg_end;
  } sts_t;

endpackage

FILE: rtl/uds_fds_dp.sv
// ----------------------------------------------------------------------------
// Flash download sequencer datapath
// Block bookkeeping, CRC, progress arithmetic and request byte selection.
// ----------------------------------------------------------------------------
module uds_fds_dp import uds_fds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  cmd_t        cmd_i,
  input  logic [15:0] tail_i,
  input  logic [7:0]  data_byte_i,
  output sts_t        sts_o,
  output logic [7:0]  byte_o,
  output logic        last_o,
  output logic [6:0]  progress_o
);

  logic [6:0]  prog_q, prog_d;
  logic [15:0] bl_q, bl_d;
  logic [7:0]  bn_q, bn_d;
  logic [15:0] left_q, left_d;
  logic [31:0] sent_q, sent_d;
  logic [15:0] crc_q, crc_d;
  logic        busy_q, busy_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [38:0] rem_q, rem_d;
  logic [6:0]  quo_q, quo_d;
  logic [7:0]  db_q;

  logic [31:0] len, sent_cap, rem_img, chunk32;
  logic [8:0]  span9, pdiv, padd;
  logic [6:0]  span, frac, end_sat, beg_sat;
  logic [38:0] prod, dvs;
  logic [15:0] crc_n;
  logic [3:0]  ek;
  logic        msg_end;

  function automatic logic [6:0] sat100(input logic [8:0] v);
    return (v > 9'(PROG_MAX)) ? PROG_MAX : v[6:0];
  endfunction

  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
    unique case (k)
      2'd0:    return v[31:24];
      2'd1:    return v[23:16];
      2'd2:    return v[15:8];
      default: return v[7:0];
    endcase
  endfunction

  assign len      = cfg_i.image_length;
  assign sent_cap = (sent_q < len) ? sent_q : len;
  assign rem_img  = (sent_q < len) ? (len - sent_q) : 32'd0;
  assign chunk32  = (rem_img < ({16'd0, bl_q} - 32'd2)) ? rem_img : ({16'd0, bl_q} - 32'd2);
  assign span9    = {2'b00, cfg_i.end_progress} - {2'b00, cfg_i.begin_progress} - 9'd4;
  assign span     = span9[8] ? 7'd0 : span9[6:0];
  assign prod     = 39'(span) * 39'(sent_cap);
  assign dvs      = {7'd0, len} << cnt_q;
  assign frac     = (len == 32'd0) ? span : quo_q;
  assign pdiv     = {2'b00, cfg_i.begin_progress} + 9'd2 + {2'b00, frac};
  assign padd     = {2'b00, prog_q} + {7'd0, cmd_i.prog_add};
  assign end_sat  = sat100({2'b00, cfg_i.end_progress});
  assign beg_sat  = sat100({2'b00, cfg_i.begin_progress});

  always_comb begin
    logic [15:0] c;
    c = crc_q ^ {db_q, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    crc_n = c;
  end

  always_comb begin
    prog_d = prog_q;
    bl_d   = bl_q;
    bn_d   = bn_q;
    left_d = left_q;
    sent_d = sent_q;
    crc_d  = crc_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (cmd_i.start) begin
      bl_d = '0; bn_d = '0; left_d = '0; sent_d = '0; crc_d = CRC_INIT;
      prog_d = beg_sat;
    end
    if (cmd_i.prog_add != 2'd0) prog_d = sat100(padd);
    if (cmd_i.prog_div) prog_d = sat100(pdiv);
    if (cmd_i.prog_end) prog_d = end_sat;
    if (cmd_i.load_block) begin
      bl_d = tail_i; sent_d = '0; crc_d = CRC_INIT;
    end
    if (cmd_i.new_block) begin
      bn_d   = bn_q + 8'd1;
      left_d = chunk32[15:0];
    end
    if (cmd_i.data_step) begin
      crc_d  = crc_n;
      sent_d = sent_q + 32'd1;
      left_d = left_q - 16'd1;
    end
    if (cmd_i.div_start) begin
      busy_d = 1'b1; cnt_d = 3'd6; rem_d = prod; quo_d = '0;
    end else if (busy_q) begin
      if (rem_q >= dvs) begin
        rem_d = rem_q - dvs;
        quo_d[cnt_q] = 1'b1;
      end
      if (cnt_q == 3'd0) busy_d = 1'b0;
      else cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q <= '0; bl_q <= '0; bn_q <= '0; left_q <= '0; sent_q <= '0;
      crc_q  <= CRC_INIT; busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      prog_q <= prog_d; bl_q <= bl_d; bn_q <= bn_d; left_q <= left_d;
      sent_q <= sent_d; crc_q <= crc_d; busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.latch) db_q <= data_byte_i;
  end

  // Erase request skips the format byte unless update type 2 is selected.
  assign ek = (cfg_i.update_type != 2'd2 && cmd_i.idx >= 4'd4) ? cmd_i.idx + 4'd1 : cmd_i.idx;

  always_comb begin
    byte_o = BYTE_00;
    last_o = 1'b0;
    msg_end = 1'b0;
    unique case (cmd_i.msg)
      MSG_ERASE: begin
        priority if (ek == 4'd0) byte_o = SID_ROUTINE;
        else if (ek == 4'd1) byte_o = BYTE_01;
        else if (ek == 4'd2) byte_o = BYTE_FF;
        else if (ek == 4'd3) byte_o = BYTE_00;
        else if (ek == 4'd4) byte_o = BYTE_FMT;
        else if (ek <= 4'd8) byte_o = be_byte(cfg_i.memory_addr, 2'(ek - 4'd5));
        else byte_o = be_byte(cfg_i.memory_size, 2'(ek - 4'd9));
        last_o = (ek == 4'd12);
        msg_end = last_o;
      end
      MSG_DL: begin
        priority if (cmd_i.idx == 4'd0) byte_o = SID_DOWNLOAD;
        else if (cmd_i.idx == 4'd1) byte_o = BYTE_00;
        else if (cmd_i.idx == 4'd2) byte_o = BYTE_FMT;
        else if (cmd_i.idx <= 4'd6) byte_o = be_byte(cfg_i.memory_addr, 2'(cmd_i.idx - 4'd3));
        else byte_o = be_byte(cfg_i.memory_size, 2'(cmd_i.idx - 4'd7));
        last_o = (cmd_i.idx == 4'd10);
        msg_end = last_o;
      end
      MSG_BLOCK: begin
        byte_o = (cmd_i.idx == 4'd0) ? SID_TRANSFER : bn_q;
        last_o = (cmd_i.idx == 4'd1) && (left_q == 16'd0);
        msg_end = (cmd_i.idx == 4'd1);
      end
      MSG_EXIT: begin
        byte_o = SID_EXIT;
        last_o = 1'b1;
        msg_end = 1'b1;
      end
      MSG_CHECK: begin
        priority if (cmd_i.idx == 4'd0) byte_o = SID_ROUTINE;
        else if (cmd_i.idx == 4'd1) byte_o = BYTE_01;
        else if (cmd_i.idx == 4'd2) byte_o = BYTE_FF;
        else if (cmd_i.idx == 4'd3) byte_o = BYTE_01;
        else if (cmd_i.idx <= 4'd7) byte_o = be_byte(cfg_i.memory_addr, 2'(cmd_i.idx - 4'd4));
        else if (cmd_i.idx <= 4'd11) byte_o = be_byte(cfg_i.memory_size, 2'(cmd_i.idx - 4'd8));
        else if (cmd_i.idx == 4'd12) byte_o = crc_q[15:8];
        else byte_o = crc_q[7:0];
        last_o = (cmd_i.idx == 4'd13);
        msg_end = last_o;
      end
      default: begin
        byte_o = db_q;
        last_o = (left_q == 16'd1);
        msg_end = 1'b1;
      end
    endcase
  end

  assign sts_o = '{left_nz:     (left_q != 16'd0),
                   left_one:    (left_q == 16'd1),
                   sent_ge_len: (sent_q >= len),
                   div_busy:    busy_q,
                   msg_end:     msg_end};
  assign progress_o = cmd_i.prog_end ? end_sat : prog_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.data_step |-> left_q != 16'd0)
    else $error("data byte consumed with no room left in block");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> busy_q && cnt_q == 3'd6)
    else $error("divider did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_block |=> crc_q == CRC_INIT && sent_q == 32'd0)
    else $error("block load did not clear CRC and count");

endmodule

FILE: rtl/uds_fds_ctrl.sv
// ----------------------------------------------------------------------------
// Flash download sequencer controller
// Phase tracking and word emission sequencing.
// ----------------------------------------------------------------------------
module uds_fds_ctrl import uds_fds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        accept_i,
  input  logic [1:0]  mode_i,
  input  logic        resp_ok_i,
  input  logic [7:0]  resp_length_i,
  input  logic [15:0] resp_tail_i,
  input  sts_t        sts_i,
  input  logic        out_free_i,
  output logic        idle_o,
  output cmd_t        cmd_o,
  output logic        push_o,
  output logic        has_byte_o,
  output logic        done_o,
  output logic [1:0]  status_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_EMIT, S_BLK, S_DIV, S_FIN
  } state_e;

  typedef enum logic [2:0] {
    PH_IDLE, PH_ERASE, PH_DL, PH_DATA, PH_BLOCK, PH_EXIT, PH_CHECK, PH_DONE
  } phase_e;

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  msg_e       msg_q, msg_d;
  logic [3:0] idx_q, idx_d;
  logic [1:0] st_q, st_d;
  logic       ok_q, ok_d;
  logic       ft_erase, bad_len;

  assign ft_erase = (cfg_i.file_type == 2'd2) || (cfg_i.file_type == 2'd3);
  assign bad_len  = !((resp_length_i == 8'd4) || (resp_length_i == 8'd6)) ||
                    (resp_tail_i < 16'd3);

  always_comb begin
    state_d = state_q; phase_d = phase_q; msg_d = msg_q; idx_d = idx_q;
    st_d = st_q; ok_d = ok_q;
    cmd_o = '0;
    cmd_o.msg = msg_q;
    cmd_o.idx = idx_q;
    push_o = 1'b0; has_byte_o = 1'b0; done_o = 1'b0; status_o = ST_SUCCESS;
    unique case (state_q)
      S_IDLE: if (accept_i) begin
        cmd_o.latch = 1'b1;
        idx_d = '0;
        unique case (mode_i)
          MODE_START: begin
            cmd_o.start = 1'b1;
            priority if (cfg_i.file_type == 2'd1) begin
              phase_d = PH_DL; msg_d = MSG_DL; state_d = S_EMIT;
            end else if (ft_erase) begin
              phase_d = PH_ERASE; msg_d = MSG_ERASE; state_d = S_EMIT;
            end else begin
              st_d = ST_BAD_FT; state_d = S_FIN;
            end
          end
          MODE_RESP: begin
            unique case (phase_q)
              PH_ERASE: begin
                cmd_o.prog_add = 2'd1;
                if (resp_ok_i) begin
                  phase_d = PH_DL; msg_d = MSG_DL; state_d = S_EMIT;
                end else begin
                  st_d = ST_NEG; state_d = S_FIN;
                end
              end
              PH_DL: begin
                cmd_o.prog_add = 2'd1;
                priority if (!resp_ok_i) begin
                  st_d = ST_NEG; state_d = S_FIN;
                end else if (bad_len) begin
                  st_d = ST_BAD_LEN; state_d = S_FIN;
                end else begin
                  cmd_o.load_block = 1'b1; state_d = S_BLK;
                end
              end
              PH_BLOCK: begin
                cmd_o.div_start = 1'b1; ok_d = resp_ok_i; state_d = S_DIV;
              end
              PH_EXIT: begin
                priority if (!resp_ok_i) begin
                  cmd_o.prog_add = 2'd1; st_d = ST_NEG; state_d = S_FIN;
                end else if (ft_erase) begin
                  cmd_o.prog_add = 2'd2;
                  phase_d = PH_CHECK; msg_d = MSG_CHECK; state_d = S_EMIT;
                end else begin
                  cmd_o.prog_add = 2'd1; st_d = ST_SUCCESS; state_d = S_FIN;
                end
              end
              PH_CHECK: begin
                st_d = (resp_ok_i || cfg_i.has_file_system) ? ST_SUCCESS : ST_NEG;
                state_d = S_FIN;
              end
              default: ;
            endcase
          end
          MODE_DATA: begin
            if (phase_q == PH_DATA && sts_i.left_nz) begin
              msg_d = MSG_DATA; state_d = S_EMIT;
            end
          end
          default: ;
        endcase
      end
      S_BLK: begin
        cmd_o.new_block = 1'b1;
        msg_d = MSG_BLOCK; idx_d = '0; state_d = S_EMIT;
      end
      S_DIV: if (!sts_i.div_busy) begin
        cmd_o.prog_div = 1'b1;
        priority if (!ok_q) begin
          st_d = ST_NEG; state_d = S_FIN;
        end else if (sts_i.sent_ge_len) begin
          phase_d = PH_EXIT; msg_d = MSG_EXIT; idx_d = '0; state_d = S_EMIT;
        end else begin
          state_d = S_BLK;
        end
      end
      S_EMIT: if (out_free_i) begin
        push_o = 1'b1; has_byte_o = 1'b1;
        idx_d = idx_q + 4'd1;
        if (msg_q == MSG_DATA) begin
          cmd_o.data_step = 1'b1;
          if (sts_i.left_one) phase_d = PH_BLOCK;
        end
        if (sts_i.msg_end) begin
          state_d = S_IDLE;
          if (msg_q == MSG_BLOCK) phase_d = sts_i.left_nz ? PH_DATA : PH_BLOCK;
        end
      end
      default: if (out_free_i) begin
        push_o = 1'b1; done_o = 1'b1; status_o = st_q;
        cmd_o.prog_end = (st_q == ST_SUCCESS);
        phase_d = PH_DONE; state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; phase_q <= PH_IDLE; msg_q <= MSG_ERASE;
      idx_q <= '0; st_q <= ST_SUCCESS; ok_q <= 1'b0;
    end else begin
      state_q <= state_d; phase_q <= phase_d; msg_q <= msg_d;
      idx_q <= idx_d; st_q <= st_d; ok_q <= ok_d;
    end
  end

  assign idle_o = (state_q == S_IDLE);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !sts_i.div_busy)
    else $error("idle while the divider is running");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> out_free_i)
    else $error("word pushed into an occupied output register");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA && state_q == S_IDLE |-> sts_i.left_nz)
    else $error("streaming phase with an empty block");

endmodule

FILE: rtl/uds_flash_download_sequencer.sv
// ----------------------------------------------------------------------------
// Diagnostic flash download sequencer
// Client side of a flash download: erase, request download, transfer blocks
// with a running CRC16, transfer exit and dependency check.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake            | Word
//  cfg      | in        | cfg_valid/cfg_ready  | register index and data
//  in       | in        | in_valid/in_ready    | mode, response fields, data byte
//  out      | out       | out_valid/out_ready  | one request byte or final status
//
// Each input word is taken only while the controller is idle; the request
// bytes it causes leave one per cycle while the output register is free. A
// transfer block reply runs the progress fraction through a seven-step
// restoring divider, and through the block sizing state as well when a
// further block has to be sized. A data byte is latched, then sent.
// Reset clears all sequence state; configuration returns to its defaults.
// A stalled output register holds the controller in its emit or status
// state; no input word is taken until the current one's words are pushed.
module uds_flash_download_sequencer import uds_fds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic        resp_ok_i,
  input  logic [7:0]  resp_length_i,
  input  logic [15:0] resp_tail_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        has_byte_o,
  output logic [7:0]  req_byte_o,
  output logic        req_last_o,
  output logic [6:0]  progress_o,
  output logic        done_res_o,
  output logic [1:0]  status_o
);

  cfg_t       cfg_q;
  cmd_t       cmd;
  sts_t       sts;
  logic       idle, accept, push, out_free;
  logic       c_has, c_done, d_last;
  logic [1:0] c_status;
  logic [7:0] d_byte;
  logic [6:0] d_prog;
  logic       out_valid_q;
  logic       has_byte_q, req_last_q, done_q;
  logic [7:0] req_byte_q;
  logic [6:0] prog_q;
  logic [1:0] status_q;

  // The register file is always ready; registers are only to be written
  // while no word is in flight.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.file_type       <= 2'd1;
      cfg_q.update_type     <= 2'd1;
      cfg_q.memory_addr     <= '0;
      cfg_q.memory_size     <= '0;
      cfg_q.image_length    <= '0;
      cfg_q.begin_progress  <= '0;
      cfg_q.end_progress    <= PROG_MAX;
      cfg_q.has_file_system <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FILE_TYPE:   cfg_q.file_type       <= cfg_data_i[1:0];
        REG_UPDATE_TYPE: cfg_q.update_type     <= cfg_data_i[1:0];
        REG_MEM_ADDR:    cfg_q.memory_addr     <= cfg_data_i;
        REG_MEM_SIZE:    cfg_q.memory_size     <= cfg_data_i;
        REG_IMAGE_LEN:   cfg_q.image_length    <= cfg_data_i;
        REG_BEGIN_PROG:  cfg_q.begin_progress  <= cfg_data_i[6:0];
        REG_END_PROG:    cfg_q.end_progress    <= cfg_data_i[6:0];
        REG_HAS_FS:      cfg_q.has_file_system <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input words are only taken while the controller is waiting.
  assign in_ready_o = idle;
  assign accept     = in_valid_i && idle;

  // The output register frees up in the same cycle its word is taken.
  assign out_free = !out_valid_q || out_ready_i;

  uds_fds_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .mode_i,
    .resp_ok_i,
    .resp_length_i,
    .resp_tail_i,
    .sts_i         (sts),
    .out_free_i    (out_free),
    .idle_o        (idle),
    .cmd_o         (cmd),
    .push_o        (push),
    .has_byte_o    (c_has),
    .done_o        (c_done),
    .status_o      (c_status)
  );

  uds_fds_dp u_dp (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .tail_i      (resp_tail_i),
    .data_byte_i,
    .sts_o       (sts),
    .byte_o      (d_byte),
    .last_o      (d_last),
    .progress_o  (d_prog)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // A status word carries no byte, so byte and last are forced low there.
  always_ff @(posedge clk_i) begin
    if (push) begin
      has_byte_q <= c_has;
      req_byte_q <= c_has ? d_byte : BYTE_00;
      req_last_q <= c_has && d_last;
      prog_q     <= d_prog;
      done_q     <= c_done;
      status_q   <= c_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign has_byte_o  = has_byte_q;
  assign req_byte_o  = req_byte_q;
  assign req_last_o  = req_last_q;
  assign progress_o  = prog_q;
  assign done_res_o  = done_q;
  assign status_o    = status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !has_byte_o)
    else $error("status word carries a request byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> status_o == ST_SUCCESS)
    else $error("status reported on a byte word");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> progress_o <= PROG_MAX)
    else $error("progress above one hundred");

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Flash download sequencer testbench
// Drives download sessions (start, replies and firmware bytes) with random
// idling on both sides. A predictor in this module works out the request
// bytes and final status that each accepted word causes. The monitor checks
// every output word, field by field, against the oldest expected word.
// ----------------------------------------------------------------------------
module testbench;
  import uds_fds_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;

  typedef enum logic [1:0] {JOB_WORD, JOB_REG, JOB_DRAIN} job_kind_e;

  // One entry of the stimulus list: an input word, a register write, or a
  // pause until the block has gone quiet.
  typedef struct {
    job_kind_e   kind;
    logic [1:0]  mode;
    logic        ok;
    logic [7:0]  len;
    logic [15:0] tail;
    logic [7:0]  data;
    logic [7:0]  reg_idx;
    logic [31:0] reg_val;
  } job_t;

  // One output word as the block should send it.
  typedef struct {
    logic       has_byte;
    logic [7:0] req_byte;
    logic       req_last;
    logic [6:0] progress;
    logic       done_res;
    logic [1:0] status;
  } out_word_t;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_ERASE, SEQ_DOWNLOAD, SEQ_DATA, SEQ_BLOCK, SEQ_EXIT, SEQ_CHECK, SEQ_DONE
  } seq_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = '0;
  logic        resp_ok_i = 1'b0;
  logic [7:0]  resp_length_i = '0;
  logic [15:0] resp_tail_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        has_byte_o;
  logic [7:0]  req_byte_o;
  logic        req_last_o;
  logic [6:0]  progress_o;
  logic        done_res_o;
  logic [1:0]  status_o;

  uds_flash_download_sequencer u_top (.*);

  always #5 clk_i = ~clk_i;

  job_t      jobs[$];
  out_word_t expected_words[$];
  int        fail_count = 0;
  int        cycle_count = 0;
  int        words_accepted = 0;
  bit        stimulus_done = 1'b0;

  // Predictor copy of the registers and of the sequence state.
  cfg_t        cfg;
  seq_e        seq;
  logic [15:0] blk_len;
  logic [7:0]  blk_num;
  logic [15:0] blk_left;
  logic [31:0] sent_count;
  logic [15:0] crc;
  logic [6:0]  prog;

  function automatic logic [6:0] clip100(input logic [7:0] v);
    return (v > 8'd100) ? 7'd100 : v[6:0];
  endfunction

  function automatic void push_word(input logic hb, input logic [7:0] b, input logic last,
                                    input logic done, input logic [1:0] st);
    out_word_t w;
    w.has_byte = hb;
    w.req_byte = b;
    w.req_last = last;
    w.progress = prog;
    w.done_res = done;
    w.status   = st;
    expected_words.push_back(w);
  endfunction

  function automatic void push_req32(input logic [31:0] v, input logic last);
    push_word(1'b1, v[31:24], 1'b0, 1'b0, ST_SUCCESS);
    push_word(1'b1, v[23:16], 1'b0, 1'b0, ST_SUCCESS);
    push_word(1'b1, v[15:8], 1'b0, 1'b0, ST_SUCCESS);
    push_word(1'b1, v[7:0], last, 1'b0, ST_SUCCESS);
  endfunction

  function automatic void end_sequence(input logic [1:0] st);
    if (st == ST_SUCCESS) prog = clip100({1'b0, cfg.end_progress});
    seq = SEQ_DONE;
    push_word(1'b0, BYTE_00, 1'b0, 1'b1, st);
  endfunction

  function automatic void send_download_req();
    push_word(1'b1, SID_DOWNLOAD, 1'b0, 1'b0, ST_SUCCESS);
    push_word(1'b1, BYTE_00, 1'b0, 1'b0, ST_SUCCESS);
    push_word(1'b1, BYTE_FMT, 1'b0, 1'b0, ST_SUCCESS);
    push_req32(cfg.memory_addr, 1'b0);
    push_req32(cfg.memory_size, 1'b1);
    seq = SEQ_DOWNLOAD;
  endfunction

  function automatic void open_block();
    logic [31:0] rest;
    logic [31:0] chunk;
    rest  = (sent_count < cfg.image_length) ? cfg.image_length - sent_count : 32'd0;
    chunk = {16'd0, blk_len} - 32'd2;
    if (rest < chunk) chunk = rest;
    blk_num  = blk_num + 8'd1;
    blk_left = chunk[15:0];
    push_word(1'b1, SID_TRANSFER, 1'b0, 1'b0, ST_SUCCESS);
    push_word(1'b1, blk_num, chunk == 0, 1'b0, ST_SUCCESS);
    seq = (chunk != 0) ? SEQ_DATA : SEQ_BLOCK;
  endfunction

  // Progress after a block reply: begin + 2 plus the share of the span
  // that the bytes sent so far represent.
  function automatic void set_block_progress();
    longint span;
    longint done_bytes;
    longint frac;
    longint p;
    span = longint'(cfg.end_progress) - longint'(cfg.begin_progress) - 4;
    if (span < 0) span = 0;
    done_bytes = (sent_count < cfg.image_length) ? sent_count : cfg.image_length;
    frac = (cfg.image_length != 0) ? (span * done_bytes) / longint'(cfg.image_length) : span;
    p = longint'(cfg.begin_progress) + 2 + frac;
    prog = (p > 100) ? 7'd100 : p[6:0];
  endfunction

  function automatic void crc_update(input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    crc = c;
  endfunction

  function automatic void write_register(input logic [7:0] idx, input logic [31:0] v);
    case (idx)
      REG_FILE_TYPE:   cfg.file_type       = v[1:0];
      REG_UPDATE_TYPE: cfg.update_type     = v[1:0];
      REG_MEM_ADDR:    cfg.memory_addr     = v;
      REG_MEM_SIZE:    cfg.memory_size     = v;
      REG_IMAGE_LEN:   cfg.image_length    = v;
      REG_BEGIN_PROG:  cfg.begin_progress  = v[6:0];
      REG_END_PROG:    cfg.end_progress    = v[6:0];
      REG_HAS_FS:      cfg.has_file_system = v[0];
      default: ;
    endcase
  endfunction

  function automatic void reset_predictor();
    cfg.file_type = 2'd1;
    cfg.update_type = 2'd1;
    cfg.memory_addr = '0;
    cfg.memory_size = '0;
    cfg.image_length = '0;
    cfg.begin_progress = '0;
    cfg.end_progress = 7'd100;
    cfg.has_file_system = 1'b0;
    seq = SEQ_IDLE;
    blk_len = '0;
    blk_num = '0;
    blk_left = '0;
    sent_count = '0;
    crc = CRC_INIT;
    prog = '0;
  endfunction

  // Works out the output words caused by one accepted input word.
  function automatic void predict_download_step(input job_t j);
    bit erase_type;
    erase_type = (cfg.file_type == 2'd2) || (cfg.file_type == 2'd3);
    if (j.mode == MODE_START) begin
      blk_len = '0;
      blk_num = '0;
      blk_left = '0;
      sent_count = '0;
      crc = CRC_INIT;
      prog = clip100({1'b0, cfg.begin_progress});
      if (cfg.file_type == 2'd1) begin
        send_download_req();
      end else if (erase_type) begin
        push_word(1'b1, SID_ROUTINE, 1'b0, 1'b0, ST_SUCCESS);
        push_word(1'b1, BYTE_01, 1'b0, 1'b0, ST_SUCCESS);
        push_word(1'b1, BYTE_FF, 1'b0, 1'b0, ST_SUCCESS);
        push_word(1'b1, BYTE_00, 1'b0, 1'b0, ST_SUCCESS);
        if (cfg.update_type == 2'd2) push_word(1'b1, BYTE_FMT, 1'b0, 1'b0, ST_SUCCESS);
        push_req32(cfg.memory_addr, 1'b0);
        push_req32(cfg.memory_size, 1'b1);
        seq = SEQ_ERASE;
      end else begin
        end_sequence(ST_BAD_FT);
      end
    end else if (j.mode == MODE_RESP) begin
      case (seq)
        SEQ_ERASE: begin
          prog = clip100({1'b0, prog} + 8'd1);
          if (j.ok) send_download_req();
          else end_sequence(ST_NEG);
        end
        SEQ_DOWNLOAD: begin
          prog = clip100({1'b0, prog} + 8'd1);
          if (!j.ok) begin
            end_sequence(ST_NEG);
          end else if ((j.len != 8'd4 && j.len != 8'd6) || j.tail < 16'd3) begin
            end_sequence(ST_BAD_LEN);
          end else begin
            blk_len = j.tail;
            sent_count = '0;
            crc = CRC_INIT;
            open_block();
          end
        end
        SEQ_BLOCK: begin
          set_block_progress();
          if (!j.ok) begin
            end_sequence(ST_NEG);
          end else if (sent_count >= cfg.image_length) begin
            push_word(1'b1, SID_EXIT, 1'b1, 1'b0, ST_SUCCESS);
            seq = SEQ_EXIT;
          end else begin
            open_block();
          end
        end
        SEQ_EXIT: begin
          prog = clip100({1'b0, prog} + 8'd1);
          if (!j.ok) begin
            end_sequence(ST_NEG);
          end else if (erase_type) begin
            prog = clip100({1'b0, prog} + 8'd1);
            push_word(1'b1, SID_ROUTINE, 1'b0, 1'b0, ST_SUCCESS);
            push_word(1'b1, BYTE_01, 1'b0, 1'b0, ST_SUCCESS);
            push_word(1'b1, BYTE_FF, 1'b0, 1'b0, ST_SUCCESS);
            push_word(1'b1, BYTE_01, 1'b0, 1'b0, ST_SUCCESS);
            push_req32(cfg.memory_addr, 1'b0);
            push_req32(cfg.memory_size, 1'b0);
            push_word(1'b1, crc[15:8], 1'b0, 1'b0, ST_SUCCESS);
            push_word(1'b1, crc[7:0], 1'b1, 1'b0, ST_SUCCESS);
            seq = SEQ_CHECK;
          end else begin
            end_sequence(ST_SUCCESS);
          end
        end
        SEQ_CHECK: end_sequence((j.ok || cfg.has_file_system) ? ST_SUCCESS : ST_NEG);
        default: ;
      endcase
    end else if (j.mode == MODE_DATA) begin
      if (seq == SEQ_DATA && blk_left != 0) begin
        push_word(1'b1, j.data, blk_left == 16'd1, 1'b0, ST_SUCCESS);
        crc_update(j.data);
        sent_count = sent_count + 32'd1;
        blk_left = blk_left - 16'd1;
        if (blk_left == 0) seq = SEQ_BLOCK;
      end
    end
  endfunction

  // ---------------------------------------------------------------- stimulus
  // The generator keeps its own view of the registers so that it can build
  // well-formed sessions; the predictor only sees what is accepted.
  int          n_words = 0;
  logic [1:0]  gen_file_type = 2'd1;
  logic [31:0] gen_image_len = '0;

  function automatic void add_word(input logic [1:0] m, input logic ok, input logic [7:0] len,
                                   input logic [15:0] tail, input logic [7:0] data);
    job_t j;
    j.kind = JOB_WORD;
    j.mode = m;
    j.ok = ok;
    j.len = len;
    j.tail = tail;
    j.data = data;
    j.reg_idx = '0;
    j.reg_val = '0;
    jobs.push_back(j);
    n_words++;
  endfunction

  function automatic void add_reply(input logic ok, input logic [7:0] len,
                                    input logic [15:0] tail);
    add_word(MODE_RESP, ok, len, tail, 8'($urandom));
  endfunction

  function automatic void add_data(input logic [7:0] b);
    add_word(MODE_DATA, 1'($urandom), 8'($urandom), 16'($urandom), b);
  endfunction

  // Register writes are always preceded by a pause until the block is idle.
  function automatic void add_registers(input logic [1:0] ft, input logic [1:0] ut,
                                        input logic [31:0] addr, input logic [31:0] size,
                                        input logic [31:0] img, input logic [6:0] bp,
                                        input logic [6:0] ep, input logic fs);
    job_t j;
    logic [31:0] vals[8];
    vals = '{{30'd0, ft}, {30'd0, ut}, addr, size, img, {25'd0, bp}, {25'd0, ep}, {31'd0, fs}};
    j.kind = JOB_DRAIN;
    j.mode = '0;
    j.ok = 1'b0;
    j.len = '0;
    j.tail = '0;
    j.data = '0;
    j.reg_idx = '0;
    j.reg_val = '0;
    jobs.push_back(j);
    j.kind = JOB_REG;
    for (int i = 0; i < 8; i++) begin
      j.reg_idx = 8'(i);
      j.reg_val = vals[i];
      jobs.push_back(j);
    end
    gen_file_type = ft;
    gen_image_len = img;
  endfunction

  function automatic logic mostly_ok();
    return $urandom_range(99) < 94;
  endfunction

  // Occasional stray word: a reply, a data byte or an unused mode.
  function automatic void maybe_noise();
    if ($urandom_range(99) < 6)
      add_word(2'($urandom_range(1, 3)), 1'($urandom), 8'($urandom), 16'($urandom),
               8'($urandom));
  endfunction

  // A complete download with random content; long images are cut short after
  // max_data bytes and simply dropped by the next start.
  function automatic void add_session(input logic [15:0] blk, input int max_data);
    longint sent;
    longint chunk;
    int total;
    add_word(MODE_START, 1'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
    maybe_noise();
    if (gen_file_type == 2'd2 || gen_file_type == 2'd3)
      add_reply(mostly_ok(), 8'($urandom), 16'($urandom));
    if (gen_file_type != 2'd0)
      add_reply(mostly_ok(), $urandom_range(1) ? 8'd6 : 8'd4, blk);
    sent = 0;
    total = 0;
    do begin
      chunk = longint'(blk) - 2;
      if (longint'(gen_image_len) - sent < chunk) chunk = longint'(gen_image_len) - sent;
      for (longint k = 0; k < chunk && total < max_data; k++) begin
        add_data(8'($urandom));
        total++;
      end
      maybe_noise();
      add_reply(mostly_ok(), 8'($urandom), 16'($urandom));
      sent += chunk;
    end while (sent < longint'(gen_image_len) && total < max_data);
    add_reply(mostly_ok(), 8'($urandom), 16'($urandom));
    add_reply(mostly_ok(), 8'($urandom), 16'($urandom));
  endfunction

  function automatic void build_stimulus();
    // Replies, data bytes and the unused mode while idle after reset.
    add_reply(1'b1, 8'd4, 16'd8);
    add_data(8'hFF);
    add_word(2'd3, 1'b1, 8'hFF, 16'hFFFF, 8'hFF);
    // Boot image with an empty image and the shortest legal block.
    add_registers(2'd1, 2'd1, 32'hFFFF_FFFF, 32'h0, 32'd0, 7'd0, 7'd100, 1'b0);
    add_session(16'd3, 8);
    // Download reply of the wrong length, then a block length below three.
    add_word(MODE_START, 1'b0, 8'd0, 16'd0, 8'd0);
    add_reply(1'b1, 8'd5, 16'd8);
    add_word(MODE_START, 1'b0, 8'd0, 16'd0, 8'd0);
    add_reply(1'b1, 8'd6, 16'd2);
    // Erase with the format byte; negative erase reply; restart mid-sequence.
    add_registers(2'd2, 2'd2, 32'h1234_5678, 32'hFFFF_FFFF, 32'd5, 7'd100, 7'd100, 1'b0);
    add_word(MODE_START, 1'b0, 8'd0, 16'd0, 8'd0);
    add_reply(1'b0, 8'd4, 16'd8);
    add_word(MODE_START, 1'b0, 8'd0, 16'd0, 8'd0);
    add_session(16'hFFFF, 8);
    // Calibration file without the format byte, file system forced success.
    add_registers(2'd3, 2'd1, 32'h0, 32'h0000_1000, 32'd7, 7'd0, 7'd0, 1'b1);
    add_session(16'd4, 20);
    add_word(MODE_START, 1'b0, 8'd0, 16'd0, 8'd0);
    // Invalid file type.
    add_registers(2'd0, 2'd3, 32'h0, 32'h0, 32'd0, 7'd50, 7'd60, 1'b0);
    add_word(MODE_START, 1'b1, 8'd0, 16'd0, 8'd0);
    // Many one-byte blocks.
    add_registers(2'd1, 2'd1, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'd12, 7'd10, 7'd90, 1'b0);
    add_session(16'd3, 12);
    // Random part.
    while (n_words < 150) begin
      add_registers($urandom_range(99) < 8 ? 2'd0 : 2'($urandom_range(1, 3)),
                    2'($urandom_range(0, 3)), $urandom, $urandom,
                    ($urandom_range(99) < 5) ? $urandom : 32'($urandom_range(0, 30)),
                    ($urandom_range(99) < 10) ? 7'd127 : 7'($urandom_range(0, 100)),
                    ($urandom_range(99) < 10) ? 7'd127 : 7'($urandom_range(0, 100)),
                    1'($urandom));
      repeat ($urandom_range(1, 2))
        add_session(($urandom_range(99) < 8) ? 16'($urandom_range(3, 65535))
                                             : 16'($urandom_range(3, 12)), 20);
    end
    add_registers(2'd1, 2'd1, 32'h0, 32'h0, 32'd0, 7'd0, 7'd100, 1'b0);
  endfunction

  // ------------------------------------------------------------------ driver
  // Each side idles about 37 times in a hundred, except for a calm stretch.
  int  settle = 0;
  bit  word_held;
  bit  reg_held;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      word_held = in_valid_i;
      reg_held  = cfg_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_download_step('{JOB_WORD, mode_i, resp_ok_i, resp_length_i, resp_tail_i,
                                data_byte_i, 8'd0, 32'd0});
        words_accepted++;
        word_held = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        write_register(cfg_index_i, cfg_data_i);
        reg_held = 1'b0;
      end
      if (!word_held && !reg_held && jobs.size() > 0) begin
        case (jobs[0].kind)
          JOB_WORD: begin
            if ((words_accepted >= 60 && words_accepted < 120) || $urandom_range(99) >= 37) begin
              mode_i        <= jobs[0].mode;
              resp_ok_i     <= jobs[0].ok;
              resp_length_i <= jobs[0].len;
              resp_tail_i   <= jobs[0].tail;
              data_byte_i   <= jobs[0].data;
              word_held = 1'b1;
              void'(jobs.pop_front());
            end
          end
          JOB_REG: begin
            cfg_index_i <= jobs[0].reg_idx;
            cfg_data_i  <= jobs[0].reg_val;
            reg_held = 1'b1;
            void'(jobs.pop_front());
          end
          default: begin
            // Wait for the last expected word, then let any tail work finish.
            if (expected_words.size() != 0) begin
              settle = 0;
            end else if (settle >= SETTLE_CYCLES) begin
              settle = 0;
              void'(jobs.pop_front());
            end else begin
              settle++;
            end
          end
        endcase
      end
      if (!word_held && !reg_held && jobs.size() == 0) stimulus_done = 1'b1;
      in_valid_i  <= word_held;
      cfg_valid_i <= reg_held;
    end
  end

  // ----------------------------------------------------------------- monitor
  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_word_t w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output word: byte %0h done %0b", req_byte_o, done_res_o);
          fail_count++;
        end else begin
          w = expected_words.pop_front();
          check_field("has_byte", w.has_byte, has_byte_o);
          check_field("req_byte", w.req_byte, req_byte_o);
          check_field("req_last", w.req_last, req_last_o);
          check_field("progress", w.progress, progress_o);
          check_field("done_res", w.done_res, done_res_o);
          check_field("status", w.status, status_o);
        end
      end
      out_ready_i <= (cycle_count > 1000 && cycle_count < 2500) || $urandom_range(99) >= 37;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    reset_predictor();
    build_stimulus();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stimulus_done && expected_words.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
